[sv/uart_status_frame_receiver_unit_macros.svh]
// Assertion macros shared by the UART status frame receiver RTL.
`ifndef UART_STATUS_FRAME_RECEIVER_UNIT_MACROS_SVH
`define UART_STATUS_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define USFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define USFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/uartsfr_pkg.sv]
// Types, constants and helpers of the UART status frame receiver.
package uartsfr_pkg;

    localparam int unsigned STORED_BYTES_DEF = 22;
    localparam int unsigned IDX_W            = 9;
    localparam int unsigned GAP_W            = 16;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd200;
    localparam logic [GAP_W-1:0] IDLE_MAX  = 16'hFFFF;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        EV_STATUS  = 3'd0,
        EV_ACK     = 3'd1,
        EV_OTHER   = 3'd2,
        EV_UNKNOWN = 3'd3,
        EV_FRAMING = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        WM_MANUAL  = 3'd0,
        WM_SLEEP   = 3'd1,
        WM_AUTO    = 3'd2,
        WM_POLLEN  = 3'd3,
        WM_UNSET   = 3'd4,
        WM_UNKNOWN = 3'd5
    } t_run_mode;

    // register index on the configuration port
    localparam logic REG_GAP_LIMIT = 1'b0;

    // header positions
    localparam logic [IDX_W-1:0] POS_SOF  = 9'd0;
    localparam logic [IDX_W-1:0] POS_TYPE = 9'd1;
    localparam logic [IDX_W-1:0] POS_FREE = 9'd2;
    localparam logic [IDX_W-1:0] POS_LEN  = 9'd3;
    localparam logic [IDX_W-1:0] POS_ZERO = 9'd4;
    localparam logic [IDX_W-1:0] HDR_BYTES = 9'd5;

    // body positions read at classification
    localparam int unsigned BYTE_TYPE    = 1;
    localparam int unsigned BYTE_VARIANT = 6;
    localparam int unsigned BYTE_CMD_LO  = 7;
    localparam int unsigned BYTE_CMD_HI  = 8;
    localparam int unsigned BYTE_VER_PAT = 10;
    localparam int unsigned BYTE_VER_MIN = 11;
    localparam int unsigned BYTE_VER_MAJ = 12;
    localparam int unsigned BYTE_POWER   = 13;
    localparam int unsigned BYTE_MODE    = 14;
    localparam int unsigned BYTE_FAN     = 15;
    localparam int unsigned BYTE_DISP    = 16;
    localparam int unsigned BYTE_DCFG    = 17;
    localparam int unsigned BYTE_DMODE   = 18;
    localparam int unsigned BYTE_FILTER  = 19;
    localparam int unsigned BYTE_LOCK    = 20;
    localparam int unsigned BYTE_NIGHT   = 21;

    localparam logic [7:0] SOF_BYTE      = 8'hA5;
    localparam logic [7:0] TYPE_ACK      = 8'h12;
    localparam logic [7:0] TYPE_CMD      = 8'h22;
    localparam logic [7:0] MIN_LEN       = 8'd4;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;
    localparam logic [7:0] VARIANT_ONE   = 8'h01;
    localparam logic [7:0] STATUS_CMD_LO = 8'h60;
    localparam logic [7:0] STATUS_CMD_HI = 8'h40;
    localparam logic [7:0] MODE_UNSET    = 8'd255;

    function automatic t_run_mode decode_run_mode(input logic [7:0] raw);
        t_run_mode wm;
        if (raw <= 8'(WM_POLLEN)) begin
            wm = t_run_mode'(raw[2:0]);
        end else if (raw == MODE_UNSET) begin
            wm = WM_UNSET;
        end else begin
            wm = WM_UNKNOWN;
        end
        return wm;
    endfunction

endpackage

[sv/uart_status_frame_receiver_unit.sv]
// UART status frame receiver: frame assembly, header checks and frame classification.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------------
//  input    | in        | i_valid / o_stall   | i_opcode, i_rx_byte
//  result   | out       | o_valid / i_stall   | o_event_res, o_command_id, status fields
//  config   | in        | APB psel / penable  | paddr, pwdata, prdata, pready
//
//  One beat accepted per cycle while o_stall is low; a result is held in stage 1, then in the result register.
//  The frame store is one byte-lane memory row: written at accept, read the same edge,
//  with the accepted byte forwarded onto the read row for classification.
//  Synchronous active-low reset clears index, idle count and valids and sets the gap limit to 200;
//  the frame store is not cleared.
//  o_stall rises only while the result register is held and a result waits behind it.

`include "uart_status_frame_receiver_unit_macros.svh"

module uart_status_frame_receiver_unit
    import uartsfr_pkg::*;
#(
    parameter int unsigned STORED_BYTES = STORED_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_rx_byte,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res,
    output logic [15:0] o_command_id,
    output logic [23:0] o_mcu_version,
    output logic [7:0]  o_pwr_status,
    output logic [2:0]  o_run_mode,
    output logic [7:0]  o_fan_speed,
    output logic [7:0]  o_disp_on,
    output logic [7:0]  o_disp_cfg,
    output logic [7:0]  o_disp_style,
    output logic [7:0]  o_filter_ind,
    output logic [7:0]  o_lock_state,
    output logic [7:0]  o_night_light,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned LANE_W = $clog2(STORED_BYTES);

    typedef enum logic [1:0] {
        CHK_NEXT,
        CHK_FAIL,
        CHK_DONE
    } t_check;

    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [GAP_W-1:0] r_idle, n_idle;
    logic [GAP_W-1:0] r_gap;
    logic [7:0]       r_len;

    logic [7:0] r_mem [STORED_BYTES];
    logic [7:0] r_rd  [STORED_BYTES];
    logic [7:0] frame [STORED_BYTES];

    logic              r_s1_valid;
    logic              r_s1_fail;
    logic              r_s1_fwd;
    logic [LANE_W-1:0] r_s1_lane;
    logic [7:0]        r_s1_byte;

    logic [2:0]  r_out_event;
    logic [15:0] r_out_cmd;
    logic [23:0] r_out_ver;
    logic [7:0]  r_out_power;
    logic [2:0]  r_out_mode;
    logic [7:0]  r_out_fan;
    logic [7:0]  r_out_disp;
    logic [7:0]  r_out_dcfg;
    logic [7:0]  r_out_dmode;
    logic [7:0]  r_out_filter;
    logic [7:0]  r_out_lock;
    logic [7:0]  r_out_night;
    logic        r_out_valid;

    t_event      n_event;
    logic [15:0] n_cmd;
    logic [23:0] n_ver;
    logic [7:0]  n_power;
    t_run_mode   n_mode;
    logic [7:0]  n_fan;
    logic [7:0]  n_disp;
    logic [7:0]  n_dcfg;
    logic [7:0]  n_dmode;
    logic [7:0]  n_filter;
    logic [7:0]  n_lock;
    logic [7:0]  n_night;

    t_check chk;
    logic   accept;
    logic   is_tick;
    logic   in_store;
    logic   wr_en;
    logic   s1_load;
    logic   out_en;
    logic   s1_en;
    logic   cfg_wr;

    assign out_en   = !r_out_valid || !i_stall;
    assign s1_en    = !r_s1_valid || out_en;
    assign o_stall  = !s1_en;
    assign accept   = i_valid && !o_stall;
    assign is_tick  = (t_opcode'(i_opcode) == OP_TICK);
    assign in_store = (r_byte_index < IDX_W'(STORED_BYTES));
    assign wr_en    = accept && !is_tick && in_store;
    assign s1_load  = accept && !is_tick && (chk != CHK_NEXT);

    // header check and next index
    always_comb begin
        chk = CHK_NEXT;
        unique case (r_byte_index)
            POS_SOF:  chk = (i_rx_byte == SOF_BYTE) ? CHK_NEXT : CHK_FAIL;
            POS_TYPE: chk = (i_rx_byte == TYPE_ACK || i_rx_byte == TYPE_CMD) ?
                            CHK_NEXT : CHK_FAIL;
            POS_FREE: chk = CHK_NEXT;
            POS_LEN:  chk = (i_rx_byte >= MIN_LEN) ? CHK_NEXT : CHK_FAIL;
            POS_ZERO: chk = (i_rx_byte == ZERO_BYTE) ? CHK_NEXT : CHK_FAIL;
            default:  chk = (r_byte_index < HDR_BYTES + IDX_W'(r_len)) ? CHK_NEXT : CHK_DONE;
        endcase

        n_idle       = r_idle;
        n_byte_index = r_byte_index;
        if (is_tick) begin
            n_idle = (r_idle == IDLE_MAX) ? r_idle : r_idle + GAP_W'(1);
            if (n_idle >= r_gap) begin
                n_byte_index = '0;
            end
        end else begin
            n_idle       = '0;
            n_byte_index = (chk == CHK_NEXT) ? r_byte_index + IDX_W'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_idle       <= '0;
        end else if (accept) begin
            r_byte_index <= n_byte_index;
            r_idle       <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !is_tick && r_byte_index == POS_LEN) begin
            r_len <= i_rx_byte;
        end
    end

    // frame store: byte-lane write, whole-row registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_byte_index[LANE_W-1:0]] <= i_rx_byte;
        end
        if (s1_en) begin
            r_rd <= r_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= s1_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_fail <= (chk == CHK_FAIL);
            r_s1_fwd  <= wr_en;
            r_s1_lane <= r_byte_index[LANE_W-1:0];
            r_s1_byte <= i_rx_byte;
        end
    end

    // forward the last written byte onto the read row
    always_comb begin
        frame = r_rd;
        if (r_s1_fwd) begin
            frame[r_s1_lane] = r_s1_byte;
        end
    end

    always_comb begin
        n_event  = EV_FRAMING;
        n_cmd    = '0;
        n_ver    = '0;
        n_power  = '0;
        n_mode   = WM_MANUAL;
        n_fan    = '0;
        n_disp   = '0;
        n_dcfg   = '0;
        n_dmode  = '0;
        n_filter = '0;
        n_lock   = '0;
        n_night  = '0;
        if (r_s1_fail) begin
            n_event = EV_FRAMING;
        end else if (frame[BYTE_VARIANT] != VARIANT_ONE) begin
            n_event = EV_UNKNOWN;
        end else begin
            n_cmd = {frame[BYTE_CMD_HI], frame[BYTE_CMD_LO]};
            if (frame[BYTE_TYPE] == TYPE_ACK) begin
                n_event = EV_ACK;
            end else if (!(frame[BYTE_CMD_LO] == STATUS_CMD_LO &&
                           frame[BYTE_CMD_HI] == STATUS_CMD_HI)) begin
                n_event = EV_OTHER;
            end else begin
                n_event  = EV_STATUS;
                n_ver    = {frame[BYTE_VER_MAJ], frame[BYTE_VER_MIN], frame[BYTE_VER_PAT]};
                n_power  = frame[BYTE_POWER];
                n_mode   = decode_run_mode(frame[BYTE_MODE]);
                n_fan    = frame[BYTE_FAN];
                n_disp   = frame[BYTE_DISP];
                n_dcfg   = frame[BYTE_DCFG];
                n_dmode  = frame[BYTE_DMODE];
                n_filter = frame[BYTE_FILTER];
                n_lock   = frame[BYTE_LOCK];
                n_night  = frame[BYTE_NIGHT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_event  <= n_event;
            r_out_cmd    <= n_cmd;
            r_out_ver    <= n_ver;
            r_out_power  <= n_power;
            r_out_mode   <= n_mode;
            r_out_fan    <= n_fan;
            r_out_disp   <= n_disp;
            r_out_dcfg   <= n_dcfg;
            r_out_dmode  <= n_dmode;
            r_out_filter <= n_filter;
            r_out_lock   <= n_lock;
            r_out_night  <= n_night;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_res   = r_out_event;
    assign o_command_id  = r_out_cmd;
    assign o_mcu_version = r_out_ver;
    assign o_pwr_status  = r_out_power;
    assign o_run_mode    = r_out_mode;
    assign o_fan_speed   = r_out_fan;
    assign o_disp_on     = r_out_disp;
    assign o_disp_cfg    = r_out_dcfg;
    assign o_disp_style  = r_out_dmode;
    assign o_filter_ind  = r_out_filter;
    assign o_lock_state  = r_out_lock;
    assign o_night_light = r_out_night;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_GAP_LIMIT);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (cfg_wr) begin
            r_gap <= pwdata[GAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_GAP_LIMIT) begin
            prdata = {16'd0, r_gap};
        end
    end

    `USFR_ASSERT_NEXT(a_idx_clear_on_result, i_clk, i_rst_n,
        s1_load, r_byte_index == '0 && r_s1_valid, "result beat did not restart the frame")
    `USFR_ASSERT_NEXT(a_idle_clear_on_byte, i_clk, i_rst_n,
        accept && !is_tick, r_idle == '0, "byte beat did not clear idle count")
    `USFR_ASSERT_NOW(a_framing_fields_zero, i_clk, i_rst_n,
        r_out_valid && r_out_event == EV_FRAMING, r_out_cmd == '0 && r_out_ver == '0,
        "framing error carries nonzero fields")
    `USFR_ASSERT_NOW(a_status_only_fields, i_clk, i_rst_n,
        r_out_valid && r_out_event != EV_STATUS, r_out_ver == '0 && r_out_night == '0,
        "status fields set on a non-status result")

endmodule
